/* hw/rtl/arpc_pkg.sv */
package arpc_pkg;

   // Field widths of the request and response payloads.
   localparam int IP_W    = 32;
   localparam int MAC_W   = 48;
   localparam int STAMP_W = 16;
   localparam int FUNC_W  = 2;

   // Default table size and the reset value of the age limit.
   localparam int                 SLOTS_DEFAULT = 32;
   localparam logic [STAMP_W-1:0] MAX_AGE_RESET = 16'd15;

   // Operation codes carried in the request's func field.
   localparam logic [FUNC_W-1:0] FUNC_LOOKUP = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_TICK   = 2'd2;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_ADDR,
      ST_SCAN,
      ST_SCAN_LAST,
      ST_EVAL
   } state_type;

endpackage

/* hw/rtl/arpc_ram.sv */
module arpc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/arpc_slot_index.sv */
module arpc_slot_index #(
   parameter int SLOTS = arpc_pkg::SLOTS_DEFAULT
) (
   input  logic                     clock,
   input  logic                     load,
   input  logic [arpc_pkg::IP_W-1:0] ip_in,
   input  logic [arpc_pkg::IP_W-1:0] ip_q,
   output logic [$clog2(SLOTS)-1:0]  slot_index
);

   import arpc_pkg::*;

   localparam int IDX_W = $clog2(SLOTS);

   generate
      if ((SLOTS & (SLOTS - 1)) == 0) begin : g_pow2
         // A power-of-two table takes the low address bits directly.
         assign slot_index = ip_q[IDX_W-1:0];
      end else begin : g_recip
         // Address mod SLOTS through a multiply by the rounded-up reciprocal.
         // The quotient is exact for every 32-bit address with this scaling.
         localparam int          SH      = IP_W + IDX_W;
         localparam int          Q_W     = 65 - SH;
         localparam logic [63:0] RECIP64 = ((64'd1 << SH) + 64'(SLOTS) - 64'd1)
                                           / 64'(SLOTS);
         localparam logic [32:0] RECIP   = RECIP64[32:0];

         logic [64:0]     prod_ff;
         logic [Q_W-1:0]  quot;
         logic [IP_W-1:0] back;
         logic [IP_W-1:0] rem;

         // The product is registered at accept, the remainder formed next cycle.
         always_ff @(posedge clock) begin
            if (load) begin
               prod_ff <= {33'd0, ip_in} * {32'd0, RECIP};
            end
         end

         always_comb begin
            quot = prod_ff[64:SH];
            back = IP_W'(IP_W'(quot) * IP_W'(SLOTS));
            rem  = ip_q - back;
         end

         assign slot_index = rem[IDX_W-1:0];
      end
   endgenerate

endmodule

/* hw/rtl/arp_cache_direct_mapped_aging.sv */
// Lookup and insert: the request's slot is read from both tables and the response
// is registered; a new request can be taken while the last result is handed off.
// Tick: the stamp memory is swept one slot a cycle. Reset: a clearing pass writes
// every stamp entry as invalid, with requests stalled; configuration writes are
// taken throughout.
module arp_cache_direct_mapped_aging #(
   parameter int SLOTS = arpc_pkg::SLOTS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_write_enable,
   input  logic [arpc_pkg::STAMP_W-1:0]  csr_write_data,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [arpc_pkg::FUNC_W-1:0]   req_func,
   input  logic [arpc_pkg::IP_W-1:0]     req_ip_address,
   input  logic [arpc_pkg::MAC_W-1:0]    req_mac_in,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_hit,
   output logic [arpc_pkg::MAC_W-1:0]    rsp_mac_out
);

   import arpc_pkg::*;

   localparam int IDX_W = $clog2(SLOTS);
   localparam int ENT_W = IP_W + MAC_W;
   localparam int STM_W = STAMP_W + 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

   state_type state_ff, state_in;

   logic [FUNC_W-1:0]  func_ff;
   logic [IP_W-1:0]    ip_ff;
   logic [MAC_W-1:0]   mac_ff;
   logic [STAMP_W-1:0] seconds_ff;
   logic [STAMP_W-1:0] max_age_ff;
   logic [IDX_W-1:0]   scan_ff, scan_in;
   logic [IDX_W-1:0]   wr_idx_ff;
   logic               pend_ff;
   logic [IDX_W-1:0]   slot_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_hit_ff, rsp_hit_in;
   logic [MAC_W-1:0]   rsp_mac_ff, rsp_mac_in;

   logic               req_accept;
   logic               out_free;
   logic               scan_last;
   logic [IDX_W-1:0]   slot_index;

   logic               ent_wr_en, ent_rd_en;
   logic [ENT_W-1:0]   ent_wr_data, ent_rd_data;
   logic               stm_wr_en, stm_rd_en;
   logic [IDX_W-1:0]   stm_wr_addr, stm_rd_addr;
   logic [STM_W-1:0]   stm_wr_data, stm_rd_data;
   logic               rsp_load;

   logic [STAMP_W-1:0] age;
   logic               keep_valid;
   logic               lookup_hit;

   // Handshake: requests are taken when idle or while a result is handed off.
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign req_stall  = !((state_ff == ST_IDLE) || ((state_ff == ST_EVAL) && out_free));
   assign req_accept = req_valid && !req_stall;
   assign scan_last  = (scan_ff == LAST_IDX);

   // Slot index of the accepted address.
   arpc_slot_index #(
      .SLOTS(SLOTS)
   ) u_slot_index (
      .clock     (clock),
      .load      (req_accept),
      .ip_in     (req_ip_address),
      .ip_q      (ip_ff),
      .slot_index(slot_index)
   );

   // Address and MAC of each slot.
   arpc_ram #(
      .WIDTH(ENT_W),
      .DEPTH(SLOTS)
   ) u_entry_ram (
      .clock  (clock),
      .wr_en  (ent_wr_en),
      .wr_addr(slot_ff),
      .wr_data(ent_wr_data),
      .rd_en  (ent_rd_en),
      .rd_addr(slot_index),
      .rd_data(ent_rd_data)
   );

   // Valid mark and stamp of each slot.
   arpc_ram #(
      .WIDTH(STM_W),
      .DEPTH(SLOTS)
   ) u_stamp_ram (
      .clock  (clock),
      .wr_en  (stm_wr_en),
      .wr_addr(stm_wr_addr),
      .wr_data(stm_wr_data),
      .rd_en  (stm_rd_en),
      .rd_addr(stm_rd_addr),
      .rd_data(stm_rd_data)
   );

   // Aging compare on the stamp that the sweep has just read.
   always_comb begin
      age        = seconds_ff - stm_rd_data[STAMP_W-1:0];
      keep_valid = stm_rd_data[STAMP_W] && (age <= max_age_ff);
      lookup_hit = (func_ff == FUNC_LOOKUP) && stm_rd_data[STAMP_W]
                   && (ent_rd_data[ENT_W-1:MAC_W] == ip_ff);
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (scan_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_accept) begin
               state_in = ST_ADDR;
            end
         end
         ST_ADDR: begin
            state_in = (func_ff == FUNC_TICK) ? ST_SCAN : ST_EVAL;
         end
         ST_SCAN: begin
            if (scan_last) begin
               state_in = ST_SCAN_LAST;
            end
         end
         ST_SCAN_LAST: begin
            state_in = ST_EVAL;
         end
         ST_EVAL: begin
            if (out_free) begin
               state_in = req_accept ? ST_ADDR : ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Memory controls and response load for each state.
   always_comb begin
      ent_rd_en   = 1'b0;
      ent_wr_en   = 1'b0;
      ent_wr_data = {ip_ff, mac_ff};
      stm_rd_en   = 1'b0;
      stm_rd_addr = slot_index;
      stm_wr_en   = 1'b0;
      stm_wr_addr = wr_idx_ff;
      stm_wr_data = {keep_valid, stm_rd_data[STAMP_W-1:0]};
      rsp_load    = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            stm_wr_en   = 1'b1;
            stm_wr_addr = scan_ff;
            stm_wr_data = '0;
         end
         ST_IDLE: begin
         end
         ST_ADDR: begin
            ent_rd_en = 1'b1;
            stm_rd_en = 1'b1;
         end
         ST_SCAN: begin
            stm_rd_en   = 1'b1;
            stm_rd_addr = scan_ff;
            stm_wr_en   = pend_ff;
         end
         ST_SCAN_LAST: begin
            stm_wr_en = 1'b1;
         end
         ST_EVAL: begin
            rsp_load = out_free;
            if (out_free && (func_ff == FUNC_INSERT)) begin
               ent_wr_en   = 1'b1;
               stm_wr_en   = 1'b1;
               stm_wr_addr = slot_ff;
               stm_wr_data = {1'b1, seconds_ff};
            end
         end
         default: begin
         end
      endcase
   end

   // Sweep counter shared by the clearing pass and the tick scan.
   always_comb begin
      scan_in = scan_ff;
      if ((state_ff == ST_CLEAR) || (state_ff == ST_SCAN)) begin
         scan_in = scan_last ? '0 : scan_ff + 1'b1;
      end
   end

   // Response register.
   always_comb begin
      rsp_valid_in = rsp_stall ? rsp_valid_ff : 1'b0;
      rsp_hit_in   = rsp_hit_ff;
      rsp_mac_in   = rsp_mac_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_hit_in   = lookup_hit;
         rsp_mac_in   = lookup_hit ? ent_rd_data[MAC_W-1:0] : '0;
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         scan_ff      <= '0;
         pend_ff      <= 1'b0;
         seconds_ff   <= '0;
         max_age_ff   <= MAX_AGE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         scan_ff      <= scan_in;
         pend_ff      <= (state_ff == ST_SCAN);
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            max_age_ff <= csr_write_data;
         end
         if ((state_ff == ST_ADDR) && (func_ff == FUNC_TICK)) begin
            seconds_ff <= seconds_ff + 1'b1;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         func_ff <= req_func;
         ip_ff   <= req_ip_address;
         mac_ff  <= req_mac_in;
      end
      if (state_ff == ST_ADDR) begin
         slot_ff <= slot_index;
      end
      wr_idx_ff  <= scan_ff;
      rsp_hit_ff <= rsp_hit_in;
      rsp_mac_ff <= rsp_mac_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_hit     = rsp_hit_ff;
   assign rsp_mac_out = rsp_mac_ff;

endmodule
